FILE: hdl/wpsrb_pkg.sv
// Shared types and constants for the weighted prefix-sum row builder.
`default_nettype none
package wpsrb_pkg;
	localparam int MAX_KNOTS = 64;
	localparam int IDX_W     = $clog2(MAX_KNOTS);
	localparam int CNT_W     = 7;
	localparam int TIME_W    = 32;
	localparam int WIDTH_W   = 32;
	localparam int SURV_W    = 17;
	localparam int SUM_W     = 40;
	localparam int FRAC_W    = 16;
	localparam int NUM_W     = WIDTH_W + FRAC_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC,
		ST_SCAN,
		ST_SCAN_END,
		ST_HI_RD,
		ST_HI_LATCH,
		ST_COL_CALC,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: hdl/weighted_prefix_sum_row_builder_unit.sv
// Top level: knot loading with running weight sum, and row building per query.
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  cmd, entry_index, knot_time, interval_width,
//                                     survival, query_time
//  row      out  row_valid/row_stall  column, weight_sum, last
//  cfg      in   cfg_we               cfg_wdata (knot_count)
//
// A load runs through the 48-step bit-serial divider.
// A query scans the knots and then emits one row item per column, with its pace
// set by the single read port of each knot memory.
// Reset clears control state and the running total and sets knot_count to 1.
// req_stall is high while an item is in work; a stalled row item holds in the output register.
`default_nettype none
module weighted_prefix_sum_row_builder_unit import wpsrb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               cmd,
	input  wire logic [IDX_W-1:0]   entry_index,
	input  wire logic [TIME_W-1:0]  knot_time,
	input  wire logic [WIDTH_W-1:0] interval_width,
	input  wire logic [SURV_W-1:0]  survival,
	input  wire logic [TIME_W-1:0]  query_time,
	output logic                    row_valid,
	input  wire logic               row_stall,
	output logic [IDX_W-1:0]        column,
	output logic [SUM_W-1:0]        weight_sum,
	output logic                    last,
	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   cfg_wdata
);
	state_t state_q, state_d;

	logic [CNT_W-1:0]  knot_count_q;
	logic [CNT_W-1:0]  cnt_act;
	logic [CNT_W-1:0]  cnt_m1;
	logic [IDX_W-1:0]  last_idx;

	logic [IDX_W-1:0]  slot_q;
	logic [TIME_W-1:0] query_q;
	logic [SUM_W-1:0]  total_q;
	logic [SUM_W-1:0]  total_d;
	logic [SUM_W:0]    sum_wide;

	logic [IDX_W-1:0]  scan_k_q;
	logic              cmp_vld_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic [IDX_W-1:0]  upper_q;
	logic              found_q;
	logic [CNT_W-1:0]  past_col_q;
	logic              past_seen_q;
	logic [SUM_W-1:0]  hi_q;
	logic [IDX_W-1:0]  col_q;
	logic [SUM_W-1:0]  lo;
	logic [SUM_W-1:0]  col_val;

	logic [TIME_W-1:0] knot_mem [MAX_KNOTS];
	logic [SUM_W-1:0]  prefix_mem [MAX_KNOTS];
	logic [TIME_W-1:0] knot_rd_q;
	logic [SUM_W-1:0]  prefix_rd_q;
	logic [IDX_W-1:0]  prefix_raddr;

	logic              row_valid_q;
	logic [IDX_W-1:0]  column_q;
	logic [SUM_W-1:0]  weight_sum_q;
	logic              last_q;

	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_term;
	logic              req_take;

	wpsrb_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.width_in (interval_width),
		.surv_in  (survival),
		.done     (div_done),
		.term     (div_term)
	);

	always_comb begin
		if (knot_count_q == '0) begin
			cnt_act = CNT_W'(1);
		end else if (knot_count_q > CNT_W'(MAX_KNOTS)) begin
			cnt_act = CNT_W'(MAX_KNOTS);
		end else begin
			cnt_act = knot_count_q;
		end
	end
	assign cnt_m1   = cnt_act - 1'b1;
	assign last_idx = cnt_m1[IDX_W-1:0];

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;

	assign sum_wide = {1'b0, total_q} + {1'b0, div_term};
	always_comb begin
		if (slot_q == '0) begin
			total_d = div_term;
		end else if (sum_wide[SUM_W]) begin
			total_d = SUM_MAX;
		end else begin
			total_d = sum_wide[SUM_W-1:0];
		end
	end

	assign lo = (col_q == '0) ? '0 : prefix_rd_q;
	assign col_val = (found_q && ({1'b0, col_q} < past_col_q) && (hi_q > lo)) ? hi_q - lo : '0;

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		prefix_raddr = col_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (cmd == CMD_QUERY) begin
						state_d = ST_SCAN;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_k_q == last_idx) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_HI_RD;
			end
			ST_HI_RD: begin
				prefix_raddr = upper_q;
				state_d      = ST_HI_LATCH;
			end
			ST_HI_LATCH: begin
				state_d = ST_COL_CALC;
			end
			ST_COL_CALC: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!row_stall) begin
					state_d = last_q ? ST_IDLE : ST_COL_CALC;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			knot_count_q <= CNT_W'(1);
			total_q      <= '0;
			row_valid_q  <= 1'b0;
			cmp_vld_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= (state_q == ST_SCAN);
			if (cfg_we) begin
				knot_count_q <= cfg_wdata;
			end
			if (state_q == ST_ACC) begin
				total_q <= total_d;
			end
			if (state_q == ST_COL_CALC) begin
				row_valid_q <= 1'b1;
			end else if (state_q == ST_OUT && !row_stall) begin
				row_valid_q <= 1'b0;
			end
		end
	end

	// query bookkeeping and output payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			slot_q      <= entry_index;
			query_q     <= query_time;
			scan_k_q    <= '0;
			col_q       <= '0;
			found_q     <= 1'b0;
			past_seen_q <= 1'b0;
			past_col_q  <= cnt_act;
		end
		if (state_q == ST_SCAN) begin
			scan_k_q <= scan_k_q + 1'b1;
		end
		cmp_idx_q <= scan_k_q;
		if (cmp_vld_q) begin
			if (knot_rd_q <= query_q) begin
				upper_q <= cmp_idx_q;
				found_q <= 1'b1;
			end
			if (!past_seen_q && !(query_q > knot_rd_q)) begin
				past_col_q  <= {1'b0, cmp_idx_q};
				past_seen_q <= 1'b1;
			end
		end
		if (state_q == ST_HI_LATCH) begin
			hi_q <= prefix_rd_q;
		end
		if (state_q == ST_COL_CALC) begin
			column_q     <= col_q;
			weight_sum_q <= col_val;
			last_q       <= (col_q == last_idx);
		end
		if (state_q == ST_OUT && !row_stall) begin
			col_q <= col_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take && cmd == CMD_LOAD) begin
			knot_mem[entry_index] <= knot_time;
		end
		knot_rd_q <= knot_mem[scan_k_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			prefix_mem[slot_q] <= total_d;
		end
		prefix_rd_q <= prefix_mem[prefix_raddr];
	end

	assign row_valid  = row_valid_q;
	assign column     = column_q;
	assign weight_sum = weight_sum_q;
	assign last       = last_q;
endmodule
`default_nettype wire

FILE: hdl/wpsrb_divider.sv
// Restoring divider: saturated (width << 16) / max(survival, 1), one quotient bit per cycle.
`default_nettype none
module wpsrb_divider import wpsrb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [WIDTH_W-1:0] width_in,
	input  wire logic [SURV_W-1:0]  surv_in,
	output logic                    done,
	output logic [SUM_W-1:0]        term
);
	logic [NUM_W-1:0]  num_q;
	logic [SURV_W-1:0] rem_q;
	logic [SURV_W-1:0] den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SURV_W:0]   shifted;
	logic              ge;
	logic [SURV_W:0]   diff;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {width_in, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= (surv_in == '0) ? SURV_W'(1) : surv_in;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[SURV_W-1:0] : shifted[SURV_W-1:0];
		end
	end

	assign done = done_q;
	assign term = (|num_q[NUM_W-1:SUM_W]) ? SUM_MAX : num_q[SUM_W-1:0];
endmodule
`default_nettype wire
